// ----- design/bti_pkg.sv -----
// Shared types, sizes and helpers of the bilinear table interpolator.
// No dependencies; bti_locate, bti_blend and the top level import this package.
package bti_pkg;

    // Table geometry (row-major) and backing store
    localparam int ROWS        = 32;
    localparam int COLS        = 32;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Grid index width, large enough for the last row and the last column
    localparam int MAX_DIM = (ROWS > COLS) ? ROWS : COLS;
    localparam int IDX_W   = $clog2(MAX_DIM);

    // Linear address width before wrapping into the store
    localparam int LIN_RAW = $clog2(ROWS * COLS);
    localparam int LIN_W   = (LIN_RAW > ADDR_W) ? LIN_RAW : ADDR_W;

    // Number formats
    localparam int COORD_W  = 24;   // Q8.16 coordinates and registers
    localparam int SAMPLE_W = 32;   // Q8.24 samples
    localparam int FRAC_W   = 16;   // Q0.16 fraction
    localparam int WGT_W    = FRAC_W + 1;
    localparam int IPOS_W   = 32;   // Q16.16 grid position

    // 1.0 in Q0.16, with room for the carry
    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(1) << FRAC_W;

    // Register reset values
    localparam logic [COORD_W-1:0] LIMIT_RST = {COORD_W{1'b1}};
    localparam logic [COORD_W-1:0] STEP_RST  = COORD_W'(1) << FRAC_W;

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q_ORIGIN   = 3'd0,
        CFG_Q_LIMIT    = 3'd1,
        CFG_Q_INV_STEP = 3'd2,
        CFG_P_ORIGIN   = 3'd3,
        CFG_P_LIMIT    = 3'd4,
        CFG_P_INV_STEP = 3'd5
    } cfg_reg_t;

    // Position along one axis: the two neighbor indexes and the fraction
    typedef struct packed {
        logic [IDX_W-1:0]  i0;
        logic [IDX_W-1:0]  i1;
        logic [FRAC_W-1:0] frac;
    } loc_t;

    // Row-major store address, wrapping modulo the store depth
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] col);
        logic [LIN_W-1:0] lin;
        lin = LIN_W'(row) * LIN_W'(COLS) + LIN_W'(col);
        return lin[ADDR_W-1:0];
    endfunction

endpackage

// ----- design/bti_ram.sv -----
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies. A read of the entry being written returns the old data.
module bti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- design/bti_locate.sv -----
// One axis of the interpolator: clamp, offset, reciprocal scale, index clamp.
// Depends on bti_pkg. Three register stages, one coordinate per cycle.
module bti_locate (
    input  logic                          clk,
    input  logic [bti_pkg::COORD_W-1:0]   coord,
    input  logic [bti_pkg::COORD_W-1:0]   origin,
    input  logic [bti_pkg::COORD_W-1:0]   limit,
    input  logic [bti_pkg::COORD_W-1:0]   inv_step,
    input  logic [bti_pkg::IDX_W-1:0]     last,
    output bti_pkg::loc_t                 loc
);
    import bti_pkg::*;

    logic [COORD_W-1:0]   raised;
    logic [COORD_W-1:0]   lowered;
    logic [COORD_W-1:0]   off_next;
    logic [COORD_W-1:0]   off_reg;
    logic [2*COORD_W-1:0] prod;
    logic [IPOS_W-1:0]    pos_reg;
    logic [FRAC_W-1:0]    ip;
    loc_t                 loc_next;
    loc_t                 loc_reg;

    // Stage 1: raise to origin, lower to limit, offset (zero if limit < origin)
    always_comb
    begin
        raised   = (coord < origin) ? origin : coord;
        lowered  = (raised > limit) ? limit : raised;
        off_next = (lowered < origin) ? '0 : lowered - origin;
    end

    // Stage 2: Q8.16 offset times Q8.16 reciprocal, keep Q16.16
    assign prod = (2*COORD_W)'(off_reg) * (2*COORD_W)'(inv_step);

    // Stage 3: clamp to the last grid point, fraction forced to zero there
    assign ip = pos_reg[IPOS_W-1:FRAC_W];

    always_comb
    begin
        if (ip >= FRAC_W'(last))
        begin
            loc_next.i0   = last;
            loc_next.i1   = last;
            loc_next.frac = '0;
        end
        else
        begin
            loc_next.i0   = ip[IDX_W-1:0];
            loc_next.i1   = ip[IDX_W-1:0] + IDX_W'(1);
            loc_next.frac = pos_reg[FRAC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        pos_reg <= prod[FRAC_W +: IPOS_W];
        loc_reg <= loc_next;
    end

    assign loc = loc_reg;

endmodule

// ----- design/bti_blend.sv -----
// Bilinear blend: weights from the two fractions, four products, a sum.
// Depends on bti_pkg. Weights registered on the same edge as the table read.
module bti_blend (
    input  logic                          clk,
    input  bti_pkg::loc_t                 loc_q,
    input  bti_pkg::loc_t                 loc_p,
    input  logic [bti_pkg::SAMPLE_W-1:0]  v00,
    input  logic [bti_pkg::SAMPLE_W-1:0]  v10,
    input  logic [bti_pkg::SAMPLE_W-1:0]  v01,
    input  logic [bti_pkg::SAMPLE_W-1:0]  v11,
    output logic [bti_pkg::SAMPLE_W-1:0]  result
);
    import bti_pkg::*;

    localparam int WP_W  = 2 * WGT_W;           // weight product
    localparam int PR_W  = SAMPLE_W + WGT_W;    // sample times weight
    localparam int PS_W  = PR_W + 1;            // pair sum
    localparam int AC_W  = PS_W + 1;            // full sum
    localparam int SH_W  = AC_W - FRAC_W;       // after the shift

    logic [WGT_W-1:0]    t;
    logic [WGT_W-1:0]    s;
    logic [WGT_W-1:0]    ct;
    logic [WGT_W-1:0]    cs;
    logic [WP_W-1:0]     wp00;
    logic [WP_W-1:0]     wp10;
    logic [WP_W-1:0]     wp01;
    logic [WP_W-1:0]     wp11;
    logic [WGT_W-1:0]    w00_reg;
    logic [WGT_W-1:0]    w10_reg;
    logic [WGT_W-1:0]    w01_reg;
    logic [WGT_W-1:0]    w11_reg;
    logic [PR_W-1:0]     p00_reg;
    logic [PR_W-1:0]     p10_reg;
    logic [PR_W-1:0]     p01_reg;
    logic [PR_W-1:0]     p11_reg;
    logic [PS_W-1:0]     sum_a_reg;
    logic [PS_W-1:0]     sum_b_reg;
    logic [AC_W-1:0]     acc;
    logic [SH_W-1:0]     acc_sh;
    logic [SAMPLE_W-1:0] result_next;
    logic [SAMPLE_W-1:0] result_reg;

    // Weights, each truncated to Q0.16 (1.0 fits in the carry bit)
    assign t  = WGT_W'(loc_q.frac);
    assign s  = WGT_W'(loc_p.frac);
    assign ct = ONE_Q16 - t;
    assign cs = ONE_Q16 - s;

    assign wp00 = WP_W'(ct) * WP_W'(cs);
    assign wp10 = WP_W'(t)  * WP_W'(cs);
    assign wp01 = WP_W'(ct) * WP_W'(s);
    assign wp11 = WP_W'(t)  * WP_W'(s);

    // Final sum, dropped to Q8.24 and saturated
    assign acc    = AC_W'(sum_a_reg) + AC_W'(sum_b_reg);
    assign acc_sh = acc[AC_W-1:FRAC_W];

    always_comb
    begin
        if (|acc_sh[SH_W-1:SAMPLE_W])
        begin
            result_next = '1;
        end
        else
        begin
            result_next = acc_sh[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        // weights, aligned with the table read
        w00_reg   <= wp00[FRAC_W +: WGT_W];
        w10_reg   <= wp10[FRAC_W +: WGT_W];
        w01_reg   <= wp01[FRAC_W +: WGT_W];
        w11_reg   <= wp11[FRAC_W +: WGT_W];
        // sample products
        p00_reg   <= PR_W'(v00) * PR_W'(w00_reg);
        p10_reg   <= PR_W'(v10) * PR_W'(w10_reg);
        p01_reg   <= PR_W'(v01) * PR_W'(w01_reg);
        p11_reg   <= PR_W'(v11) * PR_W'(w11_reg);
        // pair sums, then the final word
        sum_a_reg <= PS_W'(p00_reg) + PS_W'(p10_reg);
        sum_b_reg <= PS_W'(p01_reg) + PS_W'(p11_reg);
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- design/bilinear_table_interpolator_core.sv -----
// Top level of the bilinear table interpolator: command port, config
// registers, sample store (two mirrored RAMs) and the pipeline control.
// Depends on bti_pkg, bti_ram, bti_locate and bti_blend.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------
//   command  | start / busy (always low) | opcode entry_index entry_value
//            |                           | q_value p_value
//   result   | done (one-cycle strobe)   | shape_factor
//   config   | cfg_valid / cfg_ready     | cfg_index cfg_data
//
// A command word is taken every cycle. A query's result word is on the ports
// for one cycle; a table write gives no word. The depth is set by the input
// capture, the locate stages (clamp and offset, multiply, index clamp), the
// RAM read and the three blend stages. Writes and reads meet the store at
// the same stage, so a query sees every write accepted before it. Reset
// clears the pipeline and the config registers; the store holds no reset
// value. The receiver cannot stall; nothing holds the pipeline.
module bilinear_table_interpolator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // command
    input  logic                            start,
    output logic                            busy,
    input  logic                            opcode,
    input  logic [bti_pkg::ADDR_W-1:0]      entry_index,
    input  logic [bti_pkg::SAMPLE_W-1:0]    entry_value,
    input  logic [bti_pkg::COORD_W-1:0]     q_value,
    input  logic [bti_pkg::COORD_W-1:0]     p_value,
    // result
    output logic                            done,
    output logic [bti_pkg::SAMPLE_W-1:0]    shape_factor,
    // config
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bti_pkg::COORD_W-1:0]     cfg_data
);
    import bti_pkg::*;

    localparam int WR_STAGE = 3;    // stage whose word meets the store
    localparam int LAST_ST  = 6;    // stage feeding the result strobe

    logic                   accept;
    logic                   cfg_we;

    // config registers
    logic [COORD_W-1:0]     q_origin_reg;
    logic [COORD_W-1:0]     q_limit_reg;
    logic [COORD_W-1:0]     q_inv_step_reg;
    logic [COORD_W-1:0]     p_origin_reg;
    logic [COORD_W-1:0]     p_limit_reg;
    logic [COORD_W-1:0]     p_inv_step_reg;

    // pipeline control
    logic [LAST_ST:0]       vld_reg;
    logic [LAST_ST:0]       op_reg;
    logic                   done_reg;

    // payload taps
    logic [COORD_W-1:0]     q_reg;
    logic [COORD_W-1:0]     p_reg;
    logic [ADDR_W-1:0]      widx_reg [0:WR_STAGE];
    logic [SAMPLE_W-1:0]    wval_reg [0:WR_STAGE];

    loc_t                   loc_q;
    loc_t                   loc_p;
    logic                   wr_en;
    logic [ADDR_W-1:0]      addr00;
    logic [ADDR_W-1:0]      addr10;
    logic [ADDR_W-1:0]      addr01;
    logic [ADDR_W-1:0]      addr11;
    logic [SAMPLE_W-1:0]    v00;
    logic [SAMPLE_W-1:0]    v10;
    logic [SAMPLE_W-1:0]    v01;
    logic [SAMPLE_W-1:0]    v11;

    // Fully pipelined: never busy, config always ready
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    // Config register writes; unmapped indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_origin_reg   <= '0;
            q_limit_reg    <= LIMIT_RST;
            q_inv_step_reg <= STEP_RST;
            p_origin_reg   <= '0;
            p_limit_reg    <= LIMIT_RST;
            p_inv_step_reg <= STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_Q_ORIGIN:   q_origin_reg   <= cfg_data;
                CFG_Q_LIMIT:    q_limit_reg    <= cfg_data;
                CFG_Q_INV_STEP: q_inv_step_reg <= cfg_data;
                CFG_P_ORIGIN:   p_origin_reg   <= cfg_data;
                CFG_P_LIMIT:    p_limit_reg    <= cfg_data;
                CFG_P_INV_STEP: p_inv_step_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Valid / opcode shift line and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            op_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[LAST_ST-1:0], accept};
            op_reg   <= {op_reg[LAST_ST-1:0], opcode};
            done_reg <= vld_reg[LAST_ST] & op_reg[LAST_ST];
        end
    end

    // Input capture and write-word delay line
    always_ff @(posedge clk)
    begin
        q_reg       <= q_value;
        p_reg       <= p_value;
        widx_reg[0] <= entry_index;
        wval_reg[0] <= entry_value;
        for (int i = 1; i <= WR_STAGE; i++)
        begin
            widx_reg[i] <= widx_reg[i-1];
            wval_reg[i] <= wval_reg[i-1];
        end
    end

    // Per-axis position
    bti_locate u_loc_q (
        .clk      (clk),
        .coord    (q_reg),
        .origin   (q_origin_reg),
        .limit    (q_limit_reg),
        .inv_step (q_inv_step_reg),
        .last     (IDX_W'(ROWS - 1)),
        .loc      (loc_q)
    );

    bti_locate u_loc_p (
        .clk      (clk),
        .coord    (p_reg),
        .origin   (p_origin_reg),
        .limit    (p_limit_reg),
        .inv_step (p_inv_step_reg),
        .last     (IDX_W'(COLS - 1)),
        .loc      (loc_p)
    );

    // Store access stage: table writes and the four neighbor reads
    assign wr_en  = vld_reg[WR_STAGE] & ~op_reg[WR_STAGE];
    assign addr00 = entry_addr(loc_q.i0, loc_p.i0);
    assign addr10 = entry_addr(loc_q.i1, loc_p.i0);
    assign addr01 = entry_addr(loc_q.i0, loc_p.i1);
    assign addr11 = entry_addr(loc_q.i1, loc_p.i1);

    // Mirror for the left column pair
    bti_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram_c0 (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (widx_reg[WR_STAGE]),
        .wdata   (wval_reg[WR_STAGE]),
        .raddr_a (addr00),
        .raddr_b (addr10),
        .rdata_a (v00),
        .rdata_b (v10)
    );

    // Mirror for the right column pair
    bti_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram_c1 (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (widx_reg[WR_STAGE]),
        .wdata   (wval_reg[WR_STAGE]),
        .raddr_a (addr01),
        .raddr_b (addr11),
        .rdata_a (v01),
        .rdata_b (v11)
    );

    // Weights, products and final sum
    bti_blend u_blend (
        .clk    (clk),
        .loc_q  (loc_q),
        .loc_p  (loc_p),
        .v00    (v00),
        .v10    (v10),
        .v01    (v01),
        .v11    (v11),
        .result (shape_factor)
    );

    assign done = done_reg;

    // Every query gives a result word
    a_query_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode |-> ##8 done)
        else $error("query did not produce a result word");

    // A table write never gives a word
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !opcode |-> ##8 !done)
        else $error("table write produced a result word");

    // No word without a query behind it
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept && opcode, 8))
        else $error("result word without a query");

    // Store writes come only from accepted write words, at the access stage
    a_write_stage: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> $past(accept && !opcode, 4))
        else $error("store write out of step with the command");

endmodule
